>>> rtl/levenshtein_automaton_matcher_top_assert.svh
// Assertion macros shared by the matcher's checker.
`ifndef LEVENSHTEIN_AUTOMATON_MATCHER_TOP_ASSERT_SVH
`define LEVENSHTEIN_AUTOMATON_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LAM_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lam: implication check failed");

// Next-cycle implication, disabled during reset.
`define LAM_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lam: next-cycle check failed");

`endif

>>> rtl/lam_pkg.sv
// Types, codes and constants of the Levenshtein automaton matcher.
`default_nettype none
package lam_pkg;

  localparam int MAX_PATTERN_DEF     = 32;
  localparam int MAX_ERROR_LIMIT_DEF = 3;
  localparam int SYMBOL_BITS_DEF     = 21;

  localparam int OPCODE_W     = 2;
  localparam int CHAR_INDEX_W = 5;
  localparam int SYMBOL_W     = 21;
  localparam int SYM_EXT_W    = 32;  // widest symbol storage allowed
  localparam int LEN_W        = 6;
  localparam int ERR_W        = 2;
  localparam int COL_W        = 7;   // column index up to 127
  localparam int ROW_W        = 3;   // row index up to 7
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STEP    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ERRORS     = 2'd1;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 6'd0;
  localparam logic [ERR_W-1:0] MAX_ERRORS_RST     = 2'd1;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic [CHAR_INDEX_W-1:0] char_index;
    logic [SYMBOL_W-1:0]     symbol;
  } cmd_t;

  typedef struct packed {
    logic accepting;
    logic rejecting;
  } res_t;

  typedef struct packed {
    logic                    advance;
    logic [OPCODE_W-1:0]     opcode;
    logic [CHAR_INDEX_W-1:0] char_index;
    logic [LEN_W-1:0]        len;
    logic [ERR_W-1:0]        err;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/lam_cell.sv
// One column cell of the automaton: pattern character and all error rows at one offset.
`default_nettype none
module lam_cell #(
  parameter int COL         = 0,
  parameter int ROWS        = lam_pkg::MAX_ERROR_LIMIT_DEF + 1,
  parameter int MAX_PATTERN = lam_pkg::MAX_PATTERN_DEF,
  parameter int SYMBOL_BITS = lam_pkg::SYMBOL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lam_pkg::cell_ctrl_t    ctrl,
  input  logic [SYMBOL_BITS-1:0] sym,
  input  logic [ROWS-1:0]        a_left,
  input  logic [ROWS-1:0]        s_left,
  input  logic                   mm_left,
  input  logic                   nm_left,
  input  logic [ROWS-1:0]        v_left,
  input  logic [ROWS-1:0]        v_right,
  output logic [ROWS-1:0]        a_out,
  output logic [ROWS-1:0]        s_out,
  output logic                   mm_out,
  output logic                   nm_out,
  output logic [ROWS-1:0]        v_out,
  output logic                   acc_col,
  output logic                   any_col
);

  localparam int FW = lam_pkg::COL_W + 1;
  localparam logic [lam_pkg::COL_W-1:0] COL_V = lam_pkg::COL_W'(COL);
  localparam logic [ROWS-1:0] RESET_ROWS = (COL == 0) ? ROWS'(1) : '0;

  logic [ROWS-1:0] a;
  logic [ROWS-1:0] a_next;
  logic [ROWS-1:0] row_ok;
  logic [ROWS-1:0] nx;
  logic [ROWS-1:0] keep;
  logic [ROWS:0]   u;
  logic            m;
  logic            col_le;
  logic            col_lt;
  logic            acc_next;
  logic            any_next;

  assign col_le = COL_V <= {1'b0, ctrl.len};
  assign col_lt = COL_V <  {1'b0, ctrl.len};

  if (COL < MAX_PATTERN) begin : g_char
    logic [SYMBOL_BITS-1:0] pat;
    always_ff @(posedge clk) begin
      if (ctrl.advance && ctrl.opcode == lam_pkg::OP_LOAD &&
          {2'b00, ctrl.char_index} == COL_V) begin
        pat <= sym;
      end
    end
    assign m = (pat == sym);
  end else begin : g_end
    assign m = 1'b0;
  end

  assign mm_out = col_lt & m;
  assign nm_out = col_lt & ~m;
  assign a_out  = a;

  always_comb begin
    s_out = '0;
    nx    = '0;
    u     = '0;
    for (int e = 0; e < ROWS; e++) begin
      row_ok[e] = lam_pkg::ROW_W'(e) <= {1'b0, ctrl.err};
      // match move and end of a multi-character deletion
      nx[e] = (a_left[e] & mm_left) | (s_left[e] & mm_left);
      if (e > 0) begin
        // deletion run still looking for its matching character
        s_out[e] = nm_left & (a_left[e-1] | s_left[e-1]);
        // insertion at this offset, substitution from the left
        nx[e] = nx[e] | (a[e-1] & ~mm_out) | (a_left[e-1] & nm_left);
      end
      nx[e] = nx[e] & row_ok[e] & col_le;
    end
    // subsumption cover grows by one column per row
    for (int e = 0; e < ROWS; e++) begin
      v_out[e] = u[e] | nx[e];
      u[e+1]   = v_left[e] | v_out[e] | v_right[e];
    end
    keep = nx & ~u[ROWS-1:0];
  end

  always_comb begin
    case (ctrl.opcode)
      lam_pkg::OP_RESTART: a_next = RESET_ROWS;
      lam_pkg::OP_STEP:    a_next = keep;
      default:             a_next = a;
    endcase
    acc_next = 1'b0;
    any_next = 1'b0;
    for (int e = 0; e < ROWS; e++) begin
      if (a_next[e] && row_ok[e] && col_le) begin
        any_next = 1'b1;
        if ((FW'(COL_V) + FW'(ctrl.err)) >= (FW'(ctrl.len) + FW'(e))) begin
          acc_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= RESET_ROWS;
    end else if (ctrl.advance) begin
      a <= a_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      acc_col <= acc_next;
      any_col <= any_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/levenshtein_automaton_matcher_top.sv
// Top level of the Levenshtein automaton matcher: config, cell row and result pipeline.
// Usage:
//   cmd (valid/ready) carries one transaction per operation: load a pattern
//   character at char_index, restart the match, or step one symbol.
//   res (valid/ready) returns one transaction per command: accepting and
//   rejecting for the active set as it stands after that command.
//   cfg (valid/ready) writes pattern_length (index 0) or max_errors
//   (index 1); cfg_ready is always high. Write it only while idle.
// Timing:
//   A taken command first updates all offsets and error rows of the cell
//   row together with their per-column flags, then the flags are
//   OR-reduced into the result register. One command per cycle is taken
//   for as long as the receiver keeps res_ready high.
// Stall:
//   While res_valid waits, one more command is taken into the reduction
//   stage; after that cmd_ready drops until the receiver takes the result.
// Reset:
//   rst (synchronous) restarts the match at offset 0 with no errors, sets
//   pattern_length to 0 and max_errors to 1, and empties the pipeline.
//   Pattern characters are not cleared; load them before stepping.
`default_nettype none
module levenshtein_automaton_matcher_top #(
  parameter int MAX_PATTERN     = lam_pkg::MAX_PATTERN_DEF,
  parameter int MAX_ERROR_LIMIT = lam_pkg::MAX_ERROR_LIMIT_DEF,
  parameter int SYMBOL_BITS     = lam_pkg::SYMBOL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  lam_pkg::cmd_t                       cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output lam_pkg::res_t                       res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lam_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lam_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ROWS = MAX_ERROR_LIMIT + 1;
  localparam int COLS = MAX_PATTERN + 1;

  logic [lam_pkg::LEN_W-1:0] pattern_length;
  logic [lam_pkg::ERR_W-1:0] max_errors;
  logic [lam_pkg::LEN_W-1:0] eff_len;
  logic [lam_pkg::ERR_W-1:0] eff_err;

  logic red_valid;
  logic cmd_accept;
  logic res_load;

  lam_pkg::cell_ctrl_t            ctrl;
  logic [lam_pkg::SYM_EXT_W-1:0]  sym_ext;
  logic [SYMBOL_BITS-1:0]         sym;

  logic [ROWS-1:0] a_o  [COLS];
  logic [ROWS-1:0] s_o  [COLS];
  logic [ROWS-1:0] v_o  [COLS];
  logic [COLS-1:0] mm_o;
  logic [COLS-1:0] nm_o;
  logic [COLS-1:0] acc_col;
  logic [COLS-1:0] any_col;

  // Configuration: always ready, writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= lam_pkg::PATTERN_LENGTH_RST;
      max_errors     <= lam_pkg::MAX_ERRORS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lam_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data;
        lam_pkg::CFG_MAX_ERRORS:     max_errors     <= cfg_data[lam_pkg::ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to what the cell row holds.
  always_comb begin
    if ({1'b0, pattern_length} > lam_pkg::COL_W'(MAX_PATTERN)) begin
      eff_len = lam_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
    if ({1'b0, max_errors} > lam_pkg::ROW_W'(MAX_ERROR_LIMIT)) begin
      eff_err = lam_pkg::ERR_W'(MAX_ERROR_LIMIT);
    end else begin
      eff_err = max_errors;
    end
  end

  // Handshake: the reduction stage frees whenever its flags move on.
  assign res_load   = red_valid && (!res_valid || res_ready);
  assign cmd_ready  = !red_valid || !res_valid || res_ready;
  assign cmd_accept = cmd_valid && cmd_ready;

  // Mask the code point to the stored symbol width.
  assign sym_ext = lam_pkg::SYM_EXT_W'(cmd.symbol);
  assign sym     = sym_ext[SYMBOL_BITS-1:0];

  assign ctrl.advance    = cmd_accept;
  assign ctrl.opcode     = cmd.opcode;
  assign ctrl.char_index = cmd.char_index;
  assign ctrl.len        = eff_len;
  assign ctrl.err        = eff_err;

  // Row of cells, one per offset; deletion runs travel rightward, the
  // subsumption cover spreads to both neighbors.
  for (genvar j = 0; j < COLS; j++) begin : g_cell
    logic [ROWS-1:0] a_l;
    logic [ROWS-1:0] s_l;
    logic [ROWS-1:0] v_l;
    logic [ROWS-1:0] v_r;
    logic            mm_l;
    logic            nm_l;

    if (j == 0) begin : g_first
      assign a_l  = '0;
      assign s_l  = '0;
      assign v_l  = '0;
      assign mm_l = 1'b0;
      assign nm_l = 1'b0;
    end else begin : g_inner
      assign a_l  = a_o[j-1];
      assign s_l  = s_o[j-1];
      assign v_l  = v_o[j-1];
      assign mm_l = mm_o[j-1];
      assign nm_l = nm_o[j-1];
    end

    if (j == COLS - 1) begin : g_last
      assign v_r = '0;
    end else begin : g_right
      assign v_r = v_o[j+1];
    end

    lam_cell #(
      .COL         (j),
      .ROWS        (ROWS),
      .MAX_PATTERN (MAX_PATTERN),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sym     (sym),
      .a_left  (a_l),
      .s_left  (s_l),
      .mm_left (mm_l),
      .nm_left (nm_l),
      .v_left  (v_l),
      .v_right (v_r),
      .a_out   (a_o[j]),
      .s_out   (s_o[j]),
      .mm_out  (mm_o[j]),
      .nm_out  (nm_o[j]),
      .v_out   (v_o[j]),
      .acc_col (acc_col[j]),
      .any_col (any_col[j])
    );
  end

  // Reduction stage: column flags are held in the cells until it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_accept) begin
        red_valid <= 1'b1;
      end else if (res_load) begin
        red_valid <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.accepting <= |acc_col;
      res.rejecting <= ~(|any_col);
    end
  end

endmodule
`default_nettype wire

>>> rtl/lam_checker.sv
// Port-level assertions of the matcher, bound to its top level.
`default_nettype none
`include "levenshtein_automaton_matcher_top_assert.svh"
module lam_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          res_valid,
  input logic          res_ready,
  input lam_pkg::res_t res
);

  // a stalled result stays put
  `LAM_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))
  // back-pressure only comes from a full pipeline behind a stalled result
  `LAM_ASSERT_IMPLY(a_ready_low, clk, rst, !cmd_ready, res_valid && !res_ready)
  // one transaction fits behind a stalled result, then ready follows the receiver
  `LAM_ASSERT_NEXT(a_skid_full, clk, rst, res_valid && !res_ready && cmd_valid && cmd_ready, cmd_ready == res_ready)
  // an accepting set is never empty
  `LAM_ASSERT_IMPLY(a_flags_excl, clk, rst, res_valid, !(res.accepting && res.rejecting))

endmodule

bind levenshtein_automaton_matcher_top lam_checker u_lam_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
`default_nettype wire

>>> test/levenshtein_match_checker.sv
// Checker for the Levenshtein automaton matcher: tracks the active set and compares flags.
module levenshtein_match_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  logic                            cmd_ready,
  input  lam_pkg::cmd_t                   cmd,
  input  logic                            res_valid,
  input  logic                            res_ready,
  input  lam_pkg::res_t                   res,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lam_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lam_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              pending
);
  import lam_pkg::*;

  localparam int MAXP = MAX_PATTERN_DEF;
  localparam int MAXE = MAX_ERROR_LIMIT_DEF;
  localparam int NROW = MAXE + 1;

  logic [SYMBOL_W-1:0] pat_mem [MAXP];
  logic [MAXP:0]       live [NROW];   // bit o of row e: position (offset o, errors e)
  logic [LEN_W-1:0]    len_reg;
  logic [ERR_W-1:0]    err_reg;
  res_t                flag_queue [$];

  function automatic int used_len();
    return (len_reg > MAXP) ? MAXP : int'(len_reg);
  endfunction

  function automatic int used_err();
    return (err_reg > MAXE) ? MAXE : int'(err_reg);
  endfunction

  // Advance every live position by one symbol, then drop subsumed positions.
  function automatic void step_live(input logic [SYMBOL_W-1:0] c);
    logic [MAXP:0] nx [NROW];
    int n, k, o, e, o2, e2, lim, hit, i, d;
    logic gone;
    n = used_len();
    k = used_err();
    for (e = 0; e < NROW; e++) nx[e] = '0;
    for (e = 0; e <= k; e++) begin
      for (o = 0; o <= n; o++) begin
        if (live[e][o]) begin
          if (e < k) begin
            if (o + 1 < n) begin
              lim = (k - e + 1 < n - o) ? k - e + 1 : n - o;
              hit = -1;
              for (i = 0; i < lim; i++)
                if (hit < 0 && pat_mem[o + i] == c) hit = i;
              if (hit == 0) begin
                nx[e][o + 1] = 1'b1;
              end else begin
                nx[e + 1][o] = 1'b1;
                nx[e + 1][o + 1] = 1'b1;
                // skip ahead over deleted characters
                if (hit > 0) nx[e + hit][o + hit + 1] = 1'b1;
              end
            end else if (o + 1 == n) begin
              if (pat_mem[o] == c) begin
                nx[e][o + 1] = 1'b1;
              end else begin
                nx[e + 1][o] = 1'b1;
                nx[e + 1][o + 1] = 1'b1;
              end
            end else begin
              nx[e + 1][o] = 1'b1;
            end
          end else if (o < n && pat_mem[o] == c) begin
            nx[e][o + 1] = 1'b1;
          end
        end
      end
    end
    for (e = 0; e < NROW; e++) live[e] = '0;
    for (e = 0; e <= k; e++) begin
      for (o = 0; o <= n; o++) begin
        if (nx[e][o]) begin
          gone = 1'b0;
          for (e2 = 0; e2 < e; e2++) begin
            for (o2 = 0; o2 <= n; o2++) begin
              d = (o > o2) ? o - o2 : o2 - o;
              if (nx[e2][o2] && d <= e - e2) gone = 1'b1;
            end
          end
          if (!gone) live[e][o] = 1'b1;
        end
      end
    end
  endfunction

  // Apply one command and return the flags of the resulting active set.
  function automatic res_t predict_flags(input cmd_t c);
    res_t r;
    int n, k, o, e;
    case (c.opcode)
      OP_LOAD: pat_mem[c.char_index] = c.symbol;
      OP_RESTART: begin
        for (e = 0; e < NROW; e++) live[e] = '0;
        live[0][0] = 1'b1;
      end
      OP_STEP: step_live(c.symbol);
      default: ;
    endcase
    n = used_len();
    k = used_err();
    r.accepting = 1'b0;
    r.rejecting = 1'b1;
    for (e = 0; e <= k; e++) begin
      for (o = 0; o <= n; o++) begin
        if (live[e][o]) begin
          r.rejecting = 1'b0;
          if (n - o <= k - e) r.accepting = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    res_t want;
    int e;
    if (rst) begin
      for (e = 0; e < NROW; e++) live[e] = '0;
      live[0][0] = 1'b1;
      len_reg = PATTERN_LENGTH_RST;
      err_reg = MAX_ERRORS_RST;
      flag_queue.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          CFG_MAX_ERRORS:     err_reg = cfg_data[ERR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) flag_queue.insert(flag_queue.size(), predict_flags(cmd));
      if (res_valid && res_ready) begin
        if (flag_queue.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual accepting %0b rejecting %0b",
                   $time, res.accepting, res.rejecting);
          mismatches++;
        end else begin
          want = flag_queue.pop_front();
          if (res.accepting !== want.accepting) begin
            $display("%0t: accepting: expected %0b, actual %0b",
                     $time, want.accepting, res.accepting);
            mismatches++;
          end
          if (res.rejecting !== want.rejecting) begin
            $display("%0t: rejecting: expected %0b, actual %0b",
                     $time, want.rejecting, res.rejecting);
            mismatches++;
          end
        end
      end
    end
    pending = flag_queue.size();
  end

endmodule

>>> test/levenshtein_automaton_matcher_top_tb.sv
// Testbench top for the Levenshtein automaton matcher: clock, reset, stimulus and verdict.
module levenshtein_automaton_matcher_top_tb;
  import lam_pkg::*;

  localparam int ITEMS     = 2000;
  localparam int PAT_DEPTH = MAX_PATTERN_DEF;
  localparam int SETTLE    = 8;       // settling margin past the two-stage pipeline
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;   // unused code, must change nothing
  localparam logic [SYMBOL_W-1:0] SYM_TOP  = 21'h10FFFF;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HOLD, RX_ROTATE} rx_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_ready;
  cmd_t                   cmd       = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  res_t                   res;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int pending;

  // Stimulus-side view of the pattern and registers, used to build near-matches.
  logic [SYMBOL_W-1:0] pat_img [PAT_DEPTH];
  logic [SYMBOL_W-1:0] alpha [4] = '{21'h000061, 21'h000062, 21'h0003B1, SYM_TOP};
  int       cur_len;
  int       cur_err;
  int       sent       = 0;
  int       burst_left = 0;
  logic     tx_steady  = 1'b0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       hold_left  = 0;
  logic [7:0] rot      = 8'b1011_0010;

  always #5 clk = ~clk;

  levenshtein_automaton_matcher_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Watch all three channels, predict each result and compare.
  levenshtein_match_checker flag_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Result receiver: the stall pattern changes per phase. Open mode gives
  // stretches with no back-pressure at all; hold mode makes long stalls so
  // the command side has to back up behind the result register.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_left <= 0;
      rot <= 8'b1011_0010;
    end else begin
      rot <= {rot[6:0], rot[7]};
      case (rx_mode)
        RX_OPEN: res_ready <= 1'b1;
        RX_COIN: res_ready <= ($urandom_range(0, 9) < 6);
        RX_HOLD: begin
          if (hold_left != 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            res_ready <= 1'b0;
            hold_left <= $urandom_range(1, 12);
          end else begin
            res_ready <= 1'b1;
          end
        end
        default: res_ready <= rot[0];
      endcase
    end
  end

  function automatic logic [CHAR_INDEX_W-1:0] rand_idx();
    return CHAR_INDEX_W'($urandom_range(0, PAT_DEPTH - 1));
  endfunction

  function automatic logic [SYMBOL_W-1:0] rand_sym();
    return SYMBOL_W'($urandom_range(0, 1114111));
  endfunction

  // Mostly the small alphabet so that steps hit pattern characters often.
  function automatic logic [SYMBOL_W-1:0] pick_char();
    if ($urandom_range(0, 6) == 0) return rand_sym();
    return alpha[$urandom_range(0, 3)];
  endfunction

  // Send one command transaction. Bursts of random length are separated by
  // random gaps; valid is only lowered when a gap follows,
  // so it never drops and rises within the same edge.
  task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [CHAR_INDEX_W-1:0] idx,
                           input logic [SYMBOL_W-1:0] sym);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_steady || $urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      else gap = $urandom_range(1, 4);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd <= {op, idx, sym};
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic load_char(input logic [CHAR_INDEX_W-1:0] idx, input logic [SYMBOL_W-1:0] sym);
    pat_img[idx] = sym;
    push_item(OP_LOAD, idx, sym);
  endtask

  // Unused index bits of a step are randomized so they toggle too.
  task automatic step(input logic [SYMBOL_W-1:0] sym);
    push_item(OP_STEP, rand_idx(), sym);
  endtask

  // Feed the pattern with a few random edits: substitution, dropped character,
  // inserted character, swapped pair. Edit rate grows with the error budget.
  task automatic run_attempt();
    int edit_pct, r, i;
    edit_pct = 4 + 8 * cur_err;
    if ($urandom_range(0, 9) != 0) push_item(OP_RESTART, rand_idx(), rand_sym());
    for (i = 0; i < cur_len; i++) begin
      r = $urandom_range(0, 99);
      if (r >= edit_pct) begin
        step(pat_img[i]);
      end else begin
        case (r % 4)
          0: step(pick_char());
          1: ;
          2: begin
            step(pick_char());
            step(pat_img[i]);
          end
          default: begin
            if (i + 1 < cur_len) begin
              step(pat_img[i + 1]);
              step(pat_img[i]);
              i++;
            end else begin
              step(pat_img[i]);
            end
          end
        endcase
      end
    end
    repeat ($urandom_range(0, 2)) step(pick_char());
  endtask

  // Wait until every result is back and the pipeline has settled.
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  // Write both registers back to back; call only while idle.
  task automatic set_config(input logic [LEN_W-1:0] len, input logic [ERR_W-1:0] errs);
    cur_len = int'(len);
    cur_err = int'(errs);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_data <= CFG_DATA_W'(len);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_ERRORS;
    cfg_data <= CFG_DATA_W'(errs);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int i, ph, quota, r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill every pattern entry before the first step: entries are never
    // cleared, so a step must not compare against one that was never loaded.
    rx_mode = RX_OPEN;
    for (i = 0; i < PAT_DEPTH; i++) load_char(CHAR_INDEX_W'(i), alpha[$urandom_range(0, 3)]);
    drain();

    // Directed part: field extremes, every opcode, exact match, overrun
    // past the end, dropped first character, unused opcode.
    set_config(6'd4, 2'd1);
    rx_mode = RX_COIN;
    load_char(5'd0, '0);
    load_char(5'd31, SYM_TOP);
    load_char(5'd1, alpha[1]);
    load_char(5'd2, alpha[2]);
    load_char(5'd3, alpha[0]);
    push_item(OP_RESTART, 5'd0, '0);
    for (i = 0; i < 4; i++) step(pat_img[i]);
    step(SYM_TOP);
    step(SYM_TOP);
    push_item(OP_SPARE, 5'd31, SYM_TOP);
    push_item(OP_RESTART, 5'd31, SYM_TOP);
    for (i = 1; i < 4; i++) step(pat_img[i]);
    step('0);
    push_item(OP_SPARE, 5'd0, '0);

    // Random phases, each under its own register setting; the first few
    // hit the extremes of both registers.
    ph = 0;
    while (sent < ITEMS) begin
      drain();
      case (ph)
        0: set_config(6'd32, 2'd3);
        1: set_config(6'd0, 2'd0);
        2: set_config(6'd32, 2'd0);
        3: set_config(6'd0, 2'd3);
        4: set_config(6'd1, 2'd1);
        5: set_config(6'd2, 2'd2);
        default: begin
          if ($urandom_range(0, 9) < 7)
            set_config(LEN_W'($urandom_range(0, 12)), ERR_W'($urandom_range(0, 3)));
          else
            set_config(LEN_W'($urandom_range(13, 32)), ERR_W'($urandom_range(0, 3)));
        end
      endcase
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      tx_steady = ($urandom_range(0, 4) == 0);

      // Step the set left from the last phase: positions beyond the new
      // length or budget must be ignored and then dropped.
      repeat ($urandom_range(1, 3)) step(pick_char());
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 4)) load_char(rand_idx(), pick_char());

      quota = sent + $urandom_range(120, 200);
      while (sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 78) run_attempt();
        else if (r < 88) step(rand_sym());
        else if (r < 94) load_char(rand_idx(), pick_char());
        else if (r < 97) push_item(OP_RESTART, rand_idx(), rand_sym());
        else push_item(OP_SPARE, rand_idx(), rand_sym());
      end
      ph++;
    end

    drain();
    if (mismatches == 0) begin
      $display("levenshtein_automaton_matcher_top_tb passed");
    end else begin
      $display("levenshtein_automaton_matcher_top_tb failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("levenshtein_automaton_matcher_top_tb failed");
    $finish;
  end

endmodule

>>> levenshtein_automaton_matcher_top.f
+incdir+rtl
rtl/lam_pkg.sv
rtl/lam_cell.sv
rtl/levenshtein_automaton_matcher_top.sv
rtl/lam_checker.sv
test/levenshtein_match_checker.sv
test/levenshtein_automaton_matcher_top_tb.sv
